// ===== hdl/mrx_pkg.sv =====
// ---------------------------------------------------------------------------
// mrx_pkg: shared types and codes for the mqtt receive deframer
// result format, event codes, parser phase codes and result queue sizing
// ---------------------------------------------------------------------------
package mrx_pkg;

  // parser phases
  localparam logic [3:0] PH_HEADER   = 4'd0;
  localparam logic [3:0] PH_LEN      = 4'd1;
  localparam logic [3:0] PH_CA_FLAGS = 4'd2;
  localparam logic [3:0] PH_CA_CODE  = 4'd3;
  localparam logic [3:0] PH_CA_REST  = 4'd4;
  localparam logic [3:0] PH_TLEN_HI  = 4'd5;
  localparam logic [3:0] PH_TLEN_LO  = 4'd6;
  localparam logic [3:0] PH_TOPIC    = 4'd7;
  localparam logic [3:0] PH_ID_HI    = 4'd8;
  localparam logic [3:0] PH_ID_LO    = 4'd9;
  localparam logic [3:0] PH_MSG      = 4'd10;
  localparam logic [3:0] PH_SKIP     = 4'd11;

  // event codes
  localparam logic [2:0] EV_CONNACK_OK  = 3'd0;
  localparam logic [2:0] EV_CONNACK_REF = 3'd1;
  localparam logic [2:0] EV_TOPIC_BYTE  = 3'd2;
  localparam logic [2:0] EV_PUBACK      = 3'd3;
  localparam logic [2:0] EV_MSG_BYTE    = 3'd4;
  localparam logic [2:0] EV_PUB_END     = 3'd5;
  localparam logic [2:0] EV_PUB_TRUNC   = 3'd6;
  localparam logic [2:0] EV_LEN_ERROR   = 3'd7;

  // packet types (upper nibble of the fixed header)
  localparam logic [3:0] PKT_CONNACK = 4'h2;
  localparam logic [3:0] PKT_PUBLISH = 4'h3;

  localparam logic [2:0] LEN_MAX_BYTES  = 3'd4;
  localparam logic [7:0] CONNACK_NO_CODE = 8'hFF;

  // result queue sizing
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  data;
    logic [15:0] packet_id;
    logic [1:0]  qos_level;
    logic        last;
  } result_t;

endpackage

// ===== hdl/mrx_res_queue.sv =====
// ---------------------------------------------------------------------------
// mrx_res_queue: result queue
// four entry queue that takes zero, one or two results a cycle and, while
// pop is high, hands out one result a cycle
// ---------------------------------------------------------------------------
module mrx_res_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_n,
  input  mrx_pkg::result_t push_a,
  input  mrx_pkg::result_t push_b,
  output logic             room,
  input  logic             pop,
  output mrx_pkg::result_t head,
  output logic             not_empty
);

  mrx_pkg::result_t              mem [mrx_pkg::Q_DEPTH];
  logic [mrx_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [mrx_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [mrx_pkg::Q_CNT_W-1:0]   count;

  // room for two more, the most one request can produce
  assign room      = (count <= mrx_pkg::Q_CNT_W'(mrx_pkg::Q_DEPTH - 2));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + mrx_pkg::Q_PTR_W'(push_n);
      rd_ptr <= rd_ptr + mrx_pkg::Q_PTR_W'(pop);
      count  <= count + mrx_pkg::Q_CNT_W'(push_n) - mrx_pkg::Q_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push_a;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + mrx_pkg::Q_PTR_W'(1)] <= push_b;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (32'(count) + 32'(push_n)) <= (mrx_pkg::Q_DEPTH + 32'(pop)))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("result queue underflow");

endmodule

// ===== hdl/mqtt_rx_packet_parser.sv =====
// ---------------------------------------------------------------------------
// mqtt_rx_packet_parser: mqtt 3.1.1 receive deframer
// parses received broker bytes, one a cycle unless rx_stall is high, into topic, message, puback,
// connack and error events
// ---------------------------------------------------------------------------
//
//  channel   handshake             payload
//  --------  --------------------  ----------------------------------------
//  rx        rx_valid / rx_stall   rx_byte
//  res       res_valid / res_stall event_res, data, packet_id, qos_level, last
//
//  one byte is taken per cycle unless stalled; its results (zero, one or two)
//  are written to a four entry result queue in the same cycle and leave one
//  per cycle unless res stalls; rx_stall rises when the queue has room for
//  fewer than two results, so input runs at full rate unless res stalls: a byte
//  with two results ends a packet and the header byte after it yields none
//  rst is synchronous and returns the parser to waiting for a header byte
//  with an empty queue and the length error cleared
//
module mqtt_rx_packet_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  event_res,
  output logic [7:0]  data,
  output logic [15:0] packet_id,
  output logic [1:0]  qos_level,
  output logic        last
);

  // parser state
  logic [3:0]  phase;
  logic [7:0]  header_byte;
  logic [2:0]  length_bytes_seen;
  logic [27:0] bytes_left;
  logic [15:0] topic_length;
  logic [15:0] topic_bytes_seen;
  logic [15:0] id_accum;
  logic [7:0]  connack_code;
  logic        length_fault;

  logic [3:0]  phase_next;
  logic [7:0]  header_byte_next;
  logic [2:0]  length_bytes_seen_next;
  logic [27:0] bytes_left_next;
  logic [15:0] topic_length_next;
  logic [15:0] topic_bytes_seen_next;
  logic [15:0] id_accum_next;
  logic [7:0]  connack_code_next;
  logic        length_fault_next;

  // results of the current byte
  logic             pri_valid;
  mrx_pkg::result_t pri_res;
  logic             end_valid;
  logic             do_end;
  mrx_pkg::result_t end_res;
  logic [27:0]      len_group;
  logic [1:0]       qos;

  logic             accept;
  logic             room;
  logic [1:0]       push_n;
  mrx_pkg::result_t push_a;
  mrx_pkg::result_t push_b;
  logic             pop;
  mrx_pkg::result_t head;

  assign accept = rx_valid && !rx_stall;
  assign qos    = header_byte[2:1];

  // 7 bit length group placed by its position, low group first
  always_comb begin
    case (length_bytes_seen[1:0])
      2'd0:    len_group = {21'd0, rx_byte[6:0]};
      2'd1:    len_group = {14'd0, rx_byte[6:0], 7'd0};
      2'd2:    len_group = {7'd0, rx_byte[6:0], 14'd0};
      default: len_group = {rx_byte[6:0], 21'd0};
    endcase
  end

  always_comb begin
    phase_next             = phase;
    header_byte_next       = header_byte;
    length_bytes_seen_next = length_bytes_seen;
    bytes_left_next        = bytes_left;
    topic_length_next      = topic_length;
    topic_bytes_seen_next  = topic_bytes_seen;
    id_accum_next          = id_accum;
    connack_code_next      = connack_code;
    length_fault_next      = length_fault;
    pri_valid              = 1'b0;
    pri_res                = '0;
    do_end                 = 1'b0;
    end_valid              = 1'b0;
    end_res                = '0;

    if (length_fault) begin
      // sticky: every byte reports the error
      pri_valid         = 1'b1;
      pri_res.event_res = mrx_pkg::EV_LEN_ERROR;
    end else if (phase == mrx_pkg::PH_HEADER) begin
      header_byte_next       = rx_byte;
      length_bytes_seen_next = '0;
      bytes_left_next        = '0;
      phase_next             = mrx_pkg::PH_LEN;
    end else if (phase == mrx_pkg::PH_LEN) begin
      if (length_bytes_seen >= mrx_pkg::LEN_MAX_BYTES) begin
        // a fifth length byte
        length_fault_next = 1'b1;
        pri_valid         = 1'b1;
        pri_res.event_res = mrx_pkg::EV_LEN_ERROR;
      end else begin
        bytes_left_next        = bytes_left | len_group;
        length_bytes_seen_next = length_bytes_seen + 3'd1;
        if (!rx_byte[7]) begin
          // length complete, pick the body handler
          if (header_byte[7:4] == mrx_pkg::PKT_CONNACK) begin
            connack_code_next = mrx_pkg::CONNACK_NO_CODE;
            phase_next        = mrx_pkg::PH_CA_FLAGS;
          end else if (header_byte[7:4] == mrx_pkg::PKT_PUBLISH) begin
            topic_length_next     = '0;
            topic_bytes_seen_next = '0;
            id_accum_next         = '0;
            phase_next            = mrx_pkg::PH_TLEN_HI;
          end else begin
            phase_next = mrx_pkg::PH_SKIP;
          end
          do_end = (bytes_left_next == '0);
        end
      end
    end else begin
      // body byte
      case (phase)
        mrx_pkg::PH_CA_FLAGS: phase_next = mrx_pkg::PH_CA_CODE;
        mrx_pkg::PH_CA_CODE: begin
          connack_code_next = rx_byte;
          phase_next        = mrx_pkg::PH_CA_REST;
        end
        mrx_pkg::PH_TLEN_HI: begin
          topic_length_next = {rx_byte, 8'd0};
          phase_next        = mrx_pkg::PH_TLEN_LO;
        end
        mrx_pkg::PH_TLEN_LO: begin
          topic_length_next     = {topic_length[15:8], rx_byte};
          topic_bytes_seen_next = '0;
          if (topic_length_next != '0) begin
            phase_next = mrx_pkg::PH_TOPIC;
          end else begin
            phase_next = (qos != 2'd0) ? mrx_pkg::PH_ID_HI : mrx_pkg::PH_MSG;
          end
        end
        mrx_pkg::PH_TOPIC: begin
          pri_valid             = 1'b1;
          pri_res.event_res     = mrx_pkg::EV_TOPIC_BYTE;
          pri_res.data          = rx_byte;
          pri_res.qos_level     = qos;
          topic_bytes_seen_next = topic_bytes_seen + 16'd1;
          if (topic_bytes_seen_next == topic_length) begin
            phase_next = (qos != 2'd0) ? mrx_pkg::PH_ID_HI : mrx_pkg::PH_MSG;
          end
        end
        mrx_pkg::PH_ID_HI: begin
          id_accum_next = {rx_byte, 8'd0};
          phase_next    = mrx_pkg::PH_ID_LO;
        end
        mrx_pkg::PH_ID_LO: begin
          id_accum_next = {id_accum[15:8], rx_byte};
          if (qos == 2'd1) begin
            // qos 1 needs a puback; qos 2 and 3 only consume the id
            pri_valid         = 1'b1;
            pri_res.event_res = mrx_pkg::EV_PUBACK;
            pri_res.packet_id = id_accum_next;
            pri_res.qos_level = 2'd1;
          end
          phase_next = mrx_pkg::PH_MSG;
        end
        mrx_pkg::PH_MSG: begin
          pri_valid         = 1'b1;
          pri_res.event_res = mrx_pkg::EV_MSG_BYTE;
          pri_res.data      = rx_byte;
          pri_res.qos_level = qos;
        end
        default: ;
      endcase
      bytes_left_next = bytes_left - 28'd1;
      do_end          = (bytes_left_next == '0);
    end

    // packet end: report according to where the body stopped
    if (do_end) begin
      if (phase_next inside {mrx_pkg::PH_CA_FLAGS, mrx_pkg::PH_CA_CODE,
                             mrx_pkg::PH_CA_REST}) begin
        end_valid = 1'b1;
        if (connack_code_next == 8'd0) begin
          end_res.event_res = mrx_pkg::EV_CONNACK_OK;
        end else begin
          end_res.event_res = mrx_pkg::EV_CONNACK_REF;
          end_res.data      = connack_code_next;
        end
      end else if (phase_next == mrx_pkg::PH_MSG) begin
        end_valid         = 1'b1;
        end_res.event_res = mrx_pkg::EV_PUB_END;
        end_res.qos_level = qos;
      end else if (phase_next inside {[mrx_pkg::PH_TLEN_HI:mrx_pkg::PH_ID_LO]}) begin
        // publish ran short of topic or id
        end_valid         = 1'b1;
        end_res.event_res = mrx_pkg::EV_PUB_TRUNC;
        end_res.qos_level = qos;
      end
      phase_next = mrx_pkg::PH_HEADER;
    end
  end

  // order results: the byte's own event first, the packet end event after
  always_comb begin
    push_a = '0;
    push_b = '0;
    push_n = 2'd0;
    if (accept) begin
      if (pri_valid) begin
        push_a      = pri_res;
        push_a.last = !end_valid;
        push_b      = end_res;
        push_b.last = 1'b1;
        push_n      = end_valid ? 2'd2 : 2'd1;
      end else if (end_valid) begin
        push_a      = end_res;
        push_a.last = 1'b1;
        push_n      = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= mrx_pkg::PH_HEADER;
      header_byte       <= '0;
      length_bytes_seen <= '0;
      bytes_left        <= '0;
      topic_length      <= '0;
      topic_bytes_seen  <= '0;
      id_accum          <= '0;
      connack_code      <= mrx_pkg::CONNACK_NO_CODE;
      length_fault      <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      header_byte       <= header_byte_next;
      length_bytes_seen <= length_bytes_seen_next;
      bytes_left        <= bytes_left_next;
      topic_length      <= topic_length_next;
      topic_bytes_seen  <= topic_bytes_seen_next;
      id_accum          <= id_accum_next;
      connack_code      <= connack_code_next;
      length_fault      <= length_fault_next;
    end
  end

  // result queue decouples the input from a stalled result side
  mrx_res_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_a    (push_a),
    .push_b    (push_b),
    .room      (room),
    .pop       (pop),
    .head      (head),
    .not_empty (res_valid)
  );

  assign rx_stall  = !room;
  assign pop       = res_valid && !res_stall;
  assign event_res = head.event_res;
  assign data      = head.data;
  assign packet_id = head.packet_id;
  assign qos_level = head.qos_level;
  assign last      = head.last;

  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    length_fault |=> length_fault)
    else $error("length fault cleared without reset");

  a_len_count: assert property (@(posedge clk) disable iff (rst)
    (phase == mrx_pkg::PH_LEN) |-> (length_bytes_seen <= mrx_pkg::LEN_MAX_BYTES))
    else $error("too many length bytes counted");

  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    (push_n == 2'd2) |-> (!push_a.last && push_b.last))
    else $error("result pair with wrong last marking");

  a_fault_single: assert property (@(posedge clk) disable iff (rst)
    (accept && length_fault) |-> (push_n == 2'd1))
    else $error("length error must give exactly one result");

endmodule

// ===== tb/mrx_event_checker.sv =====
// ---------------------------------------------------------------------------
// mrx_event_checker: result checker for the mqtt receive deframer
// follows every accepted rx request, predicts the events it causes and
// compares each accepted result field by field with the oldest prediction
// ---------------------------------------------------------------------------
module mrx_event_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  input  logic        rx_stall,
  input  logic [7:0]  rx_byte,
  input  logic        res_valid,
  input  logic        res_stall,
  input  logic [2:0]  event_res,
  input  logic [7:0]  data,
  input  logic [15:0] packet_id,
  input  logic [1:0]  qos_level,
  input  logic        last,
  output int          fail_count,
  output int          pending
);

  localparam int REPORT_CAP = 200;

  typedef enum logic [3:0] {
    WAIT_HDR, READ_LEN, ACK_FLAGS, ACK_CODE, ACK_REST, TLEN_HI, TLEN_LO,
    TOPIC, ID_HI, ID_LO, MESSAGE, SKIP
  } parse_phase_t;

  // predictor state
  parse_phase_t parse_phase;
  logic [7:0]   fixed_hdr;
  logic [2:0]   len_groups;
  logic [27:0]  body_left;
  logic [15:0]  topic_len;
  logic [15:0]  topic_seen;
  logic [15:0]  id_word;
  logic [7:0]   ack_code;
  logic         len_fault;

  mrx_pkg::result_t expected_events[$];
  mrx_pkg::result_t step_events[2];
  int               step_count;
  int               mismatches = 0;

  task automatic clear_parser();
    parse_phase = WAIT_HDR;
    fixed_hdr   = '0;
    len_groups  = '0;
    body_left   = '0;
    topic_len   = '0;
    topic_seen  = '0;
    id_word     = '0;
    ack_code    = mrx_pkg::CONNACK_NO_CODE;
    len_fault   = 1'b0;
  endtask

  task automatic add_event(input logic [2:0] ev, input logic [7:0] d,
                           input logic [15:0] id, input logic [1:0] q);
    step_events[step_count] = '{event_res: ev, data: d, packet_id: id,
                                qos_level: q, last: 1'b0};
    step_count++;
  endtask

  task automatic close_packet();
    case (parse_phase)
      ACK_FLAGS, ACK_CODE, ACK_REST: begin
        if (ack_code == 8'h00) begin
          add_event(mrx_pkg::EV_CONNACK_OK, 8'h00, 16'h0000, 2'd0);
        end else begin
          add_event(mrx_pkg::EV_CONNACK_REF, ack_code, 16'h0000, 2'd0);
        end
      end
      MESSAGE: add_event(mrx_pkg::EV_PUB_END, 8'h00, 16'h0000, fixed_hdr[2:1]);
      TLEN_HI, TLEN_LO, TOPIC, ID_HI, ID_LO:
        add_event(mrx_pkg::EV_PUB_TRUNC, 8'h00, 16'h0000, fixed_hdr[2:1]);
      default: ;
    endcase
    parse_phase = WAIT_HDR;
  endtask

  task automatic topic_done();
    parse_phase = (fixed_hdr[2:1] != 2'd0) ? ID_HI : MESSAGE;
  endtask

  task automatic open_body();
    case (fixed_hdr[7:4])
      mrx_pkg::PKT_CONNACK: begin
        ack_code    = mrx_pkg::CONNACK_NO_CODE;
        parse_phase = ACK_FLAGS;
      end
      mrx_pkg::PKT_PUBLISH: begin
        topic_len   = '0;
        topic_seen  = '0;
        id_word     = '0;
        parse_phase = TLEN_HI;
      end
      default: parse_phase = SKIP;
    endcase
    if (body_left == '0) close_packet();
  endtask

  task automatic take_body(input logic [7:0] b);
    case (parse_phase)
      ACK_FLAGS: parse_phase = ACK_CODE;
      ACK_CODE: begin
        ack_code    = b;
        parse_phase = ACK_REST;
      end
      TLEN_HI: begin
        topic_len   = {b, 8'h00};
        parse_phase = TLEN_LO;
      end
      TLEN_LO: begin
        topic_len  = topic_len | {8'h00, b};
        topic_seen = '0;
        if (topic_len != '0) parse_phase = TOPIC;
        else topic_done();
      end
      TOPIC: begin
        add_event(mrx_pkg::EV_TOPIC_BYTE, b, 16'h0000, fixed_hdr[2:1]);
        topic_seen++;
        if (topic_seen == topic_len) topic_done();
      end
      ID_HI: begin
        id_word     = {b, 8'h00};
        parse_phase = ID_LO;
      end
      ID_LO: begin
        id_word = id_word | {8'h00, b};
        // only qos 1 asks for an acknowledge
        if (fixed_hdr[2:1] == 2'd1) add_event(mrx_pkg::EV_PUBACK, 8'h00, id_word, 2'd1);
        parse_phase = MESSAGE;
      end
      MESSAGE: add_event(mrx_pkg::EV_MSG_BYTE, b, 16'h0000, fixed_hdr[2:1]);
      default: ;
    endcase
    body_left = body_left - 28'd1;
    if (body_left == '0) close_packet();
  endtask

  task automatic predict_byte(input logic [7:0] b);
    step_count = 0;
    if (len_fault) begin
      add_event(mrx_pkg::EV_LEN_ERROR, 8'h00, 16'h0000, 2'd0);
    end else if (parse_phase == WAIT_HDR) begin
      fixed_hdr   = b;
      len_groups  = '0;
      body_left   = '0;
      parse_phase = READ_LEN;
    end else if (parse_phase == READ_LEN) begin
      if (len_groups >= mrx_pkg::LEN_MAX_BYTES) begin
        len_fault = 1'b1;
        add_event(mrx_pkg::EV_LEN_ERROR, 8'h00, 16'h0000, 2'd0);
      end else begin
        body_left = body_left | (28'(b[6:0]) << (7 * len_groups));
        len_groups++;
        if (!b[7]) open_body();
      end
    end else begin
      take_body(b);
    end
    for (int i = 0; i < step_count; i++) begin
      step_events[i].last = (i == step_count - 1);
      expected_events.push_back(step_events[i]);
    end
  endtask

  function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      if (mismatches < REPORT_CAP)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_result();
    mrx_pkg::result_t want;
    if (expected_events.size() == 0) begin
      if (mismatches < REPORT_CAP)
        $display("%0t: unexpected result event_res %0d data %0h packet_id %0h qos %0d last %0b",
                 $time, event_res, data, packet_id, qos_level, last);
      mismatches++;
    end else begin
      want = expected_events.pop_front();
      cmp_field("event_res", 16'(want.event_res), 16'(event_res));
      cmp_field("data", 16'(want.data), 16'(data));
      cmp_field("packet_id", want.packet_id, packet_id);
      cmp_field("qos_level", 16'(want.qos_level), 16'(qos_level));
      cmp_field("last", 16'(want.last), 16'(last));
    end
  endtask

  // results leave a register stage, so a result taken at this edge never
  // stems from the request taken at the same edge
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      expected_events.delete();
    end else begin
      if (res_valid && !res_stall) check_result();
      if (rx_valid && !rx_stall) predict_byte(rx_byte);
    end
    pending    <= expected_events.size();
    fail_count <= mismatches;
  end

endmodule

// ===== tb/mqtt_rx_packet_parser_tb.sv =====
// ---------------------------------------------------------------------------
// mqtt_rx_packet_parser_tb: testbench for the mqtt receive deframer
// feeds directed and random broker byte streams with bursty requests and a
// stalling result side; a checker beside the block predicts and compares
// ---------------------------------------------------------------------------
module mqtt_rx_packet_parser_tb;

  localparam int IDLE_LIMIT   = 5000;   // cycles without any request taken
  localparam int TAIL_CYCLES  = 16;     // settle time after the last result
  localparam int RANDOM_BYTES = 1750;

  typedef enum logic [1:0] {FLOW, LIGHT, HEAVY, PERIODIC} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [2:0]  event_res;
  logic [7:0]  data;
  logic [15:0] packet_id;
  logic [1:0]  qos_level;
  logic        last;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int burst_left = 0;
  int sent_bytes = 0;
  int prev_sent = 0;

  // bytes of the packet being built, sent in one go
  logic [7:0] pkt[$];

  // receiver stall pattern state
  stall_mode_t stall_mode = FLOW;
  int          mode_left = 0;
  int          stall_tick = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mqtt_rx_packet_parser dut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .event_res (event_res),
    .data      (data),
    .packet_id (packet_id),
    .qos_level (qos_level),
    .last      (last)
  );

  mrx_event_checker event_chk (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_byte    (rx_byte),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .event_res  (event_res),
    .data       (data),
    .packet_id  (packet_id),
    .qos_level  (qos_level),
    .last       (last),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // result side: switches between free flow, light and heavy random stalls
  // and a fixed periodic pattern, each held for a random stretch
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(16, 160);
    end
    mode_left--;
    stall_tick++;
    case (stall_mode)
      FLOW:    res_stall <= 1'b0;
      LIGHT:   res_stall <= ($urandom_range(0, 3) == 0);
      HEAVY:   res_stall <= ($urandom_range(0, 9) < 7);
      default: res_stall <= (stall_tick % 5 < 2);
    endcase
  end

  // watchdog: any request taken on either channel counts as progress
  always @(posedge clk) begin
    if (rst || (rx_valid && !rx_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one rx request; bursts of random length with random gaps in between,
  // a zero gap keeps valid high across the burst boundary
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        rx_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
  endtask

  task automatic flush_packet();
    foreach (pkt[i]) send_byte(pkt[i]);
    sent_bytes += pkt.size();
    pkt.delete();
  endtask

  // sender holds off until the checker has seen every predicted result;
  // pending is registered, hence the first wait
  task automatic drain_results();
    rx_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // remaining length, minimal groups or now and then padded with empty
  // continuation groups up to the four byte maximum
  task automatic add_length(input int v);
    int groups;
    int total;
    groups = 1;
    while (((v >> (7 * groups)) != 0) && (groups < 4)) groups++;
    total = groups;
    if ($urandom_range(0, 7) == 0) total = $urandom_range(groups, 4);
    for (int i = 0; i < total; i++)
      pkt.push_back({(i < total - 1), 7'((v >> (7 * i)) & 'h7F)});
  endtask

  // one random packet: mostly well formed publish and connack traffic with
  // random content, some cut short, plus other types and noise headers
  task automatic make_packet();
    int         kind;
    int         tlen;
    int         mlen;
    int         blen;
    logic [3:0] ptype;
    logic [1:0] qos;
    logic [7:0] hdr;
    logic [7:0] body[$];
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      qos  = 2'($urandom_range(0, 3));
      hdr  = {mrx_pkg::PKT_PUBLISH, 1'($urandom_range(0, 1)), qos,
              1'($urandom_range(0, 1))};
      tlen = $urandom_range(0, 6);
      // a few long messages need a two byte remaining length
      mlen = ($urandom_range(0, 29) == 0) ? $urandom_range(130, 300) : $urandom_range(0, 8);
      body.push_back(8'(tlen >> 8));
      body.push_back(8'(tlen));
      repeat (tlen) body.push_back(8'($urandom));
      if (qos != 2'd0) begin
        body.push_back(8'($urandom));
        body.push_back(8'($urandom));
      end
      repeat (mlen) body.push_back(8'($urandom));
      // oversized topic length, the packet runs short of it unless the message is long
      if ($urandom_range(0, 15) == 0) body[0] = 8'($urandom_range(1, 255));
      blen = body.size();
      if ($urandom_range(0, 5) == 0) blen = $urandom_range(0, blen);
    end else if (kind < 75) begin
      hdr = {mrx_pkg::PKT_CONNACK, 4'($urandom)};
      body.push_back(8'($urandom));
      body.push_back(($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom));
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) body.push_back(8'($urandom));
      blen = body.size();
      if ($urandom_range(0, 3) == 0) blen = $urandom_range(0, blen);
    end else if (kind < 88) begin
      do ptype = 4'($urandom);
      while (ptype == mrx_pkg::PKT_CONNACK || ptype == mrx_pkg::PKT_PUBLISH);
      hdr = {ptype, 4'($urandom)};
      repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
      blen = body.size();
    end else begin
      hdr = 8'($urandom);
      repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
      blen = body.size();
    end
    pkt.push_back(hdr);
    add_length(blen);
    for (int i = 0; i < blen; i++) pkt.push_back(body[i]);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // connack with zero remaining length: refused, no code
    pkt = '{8'h20, 8'h00};
    flush_packet();
    // connack accepted
    pkt = '{8'h20, 8'h02, 8'h00, 8'h00};
    flush_packet();
    // long connack refused with code 5, trailing byte ignored
    pkt = '{8'h20, 8'h03, 8'h01, 8'h05, 8'hAA};
    flush_packet();
    // short connack: refused, no code
    pkt = '{8'h20, 8'h01, 8'h00};
    flush_packet();
    // qos 1 publish: topic byte, puback request, message byte and end
    pkt = '{8'h32, 8'h06, 8'h00, 8'h01, 8'h41, 8'h12, 8'h34, 8'hFF};
    flush_packet();
    // publish with zero remaining length: truncated
    pkt = '{8'h30, 8'h00};
    flush_packet();
    // qos 2 publish, length padded to four groups, empty topic and message
    pkt = '{8'h34, 8'h84, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    flush_packet();
    // other packet type is skipped
    pkt = '{8'hC0, 8'h00};
    flush_packet();
    // qos 1 publish cut short inside the topic
    pkt = '{8'h3B, 8'h03, 8'h00, 8'h05, 8'h61};
    flush_packet();

    drain_results();

    sent_bytes = 0;
    while (sent_bytes < RANDOM_BYTES) begin
      prev_sent = sent_bytes;
      make_packet();
      flush_packet();
      // pause once halfway until every result is out
      if (sent_bytes >= RANDOM_BYTES / 2 && prev_sent < RANDOM_BYTES / 2)
        drain_results();
    end

    drain_results();

    // fifth length byte after four continuation bytes: sticky length error,
    // every byte from then on reports it
    pkt = '{8'h30, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    repeat (9) pkt.push_back(8'($urandom));
    flush_packet();

    rx_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mrx_pkg.sv
hdl/mrx_res_queue.sv
hdl/mqtt_rx_packet_parser.sv
tb/mrx_event_checker.sv
tb/mqtt_rx_packet_parser_tb.sv
